// ===== sv/thw_pkg.sv =====
// ============================================================================
// thw_pkg
// Shared widths, tar layout constants, end codes and the result record type
// for the tar header walker.
// ============================================================================
package thw_pkg;

    // Archive layout
    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_BITS  = 9;
    localparam int NAME_BYTES  = 100;
    localparam int MODE_AT     = NAME_BYTES;
    localparam int SIZE_AT     = NAME_BYTES + 24;
    localparam int SUM_AT      = NAME_BYTES + 48;
    localparam int MODE_LEN    = 8;
    localparam int SIZE_LEN    = 12;
    localparam int SUM_LEN     = 8;

    // Field widths
    localparam int OFFSET_BITS = 34;
    localparam int INDEX_BITS  = 16;
    localparam int MODE_BITS   = 21;
    localparam int SIZE_BITS   = 33;
    localparam int SUM_BITS    = 21;
    localparam int SKIP_BITS   = 25;
    localparam int LIMIT_BITS  = 16;
    localparam int LIMIT_RESET = 64;

    // Stream widths
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 128;
    localparam int OUT_USER_BITS = 3;

    // Configuration register indexes
    localparam logic REG_FILE_LIMIT = 1'b0;

    // End kinds
    localparam logic [1:0] END_NONE   = 2'd0;
    localparam logic [1:0] END_ZERO   = 2'd1;
    localparam logic [1:0] END_LIMIT  = 2'd2;
    localparam logic [1:0] END_STREAM = 2'd3;

    // One result record
    typedef struct packed {
        logic [1:0]             end_kind;
        logic                   record_valid;
        logic [SUM_BITS-1:0]    header_sum;
        logic [SIZE_BITS-1:0]   file_size;
        logic [MODE_BITS-1:0]   file_mode;
        logic [OFFSET_BITS-1:0] data_offset;
        logic [INDEX_BITS-1:0]  file_index;
    } t_thw_result;

    // Output queue status toward the front end
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } t_thw_qstat;

endpackage

// ===== sv/thw_walker.sv =====
// ============================================================================
// thw_walker
// Walk state for the tar archive: block position, skip count, header octal
// field parsing and emission of at most one record or end result per byte.
// ============================================================================
module thw_walker
    import thw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_last_byte,
    input  logic [LIMIT_BITS-1:0]   i_file_limit,
    output logic                    o_res_valid,
    output t_thw_result             o_res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [BLOCK_BITS-1:0] LAST_IN_BLOCK = BLOCK_BITS'(BLOCK_BYTES - 1);

    logic [1:0]             r_phase,    n_phase;
    logic [BLOCK_BITS-1:0]  r_byte_pos, n_byte_pos;
    logic [SKIP_BITS-1:0]   r_skip,     n_skip;
    logic [OFFSET_BITS-1:0] r_offset,   n_offset;
    logic [INDEX_BITS-1:0]  r_files,    n_files;
    logic [MODE_BITS-1:0]   r_mode,     n_mode;
    logic [SIZE_BITS-1:0]   r_size,     n_size;
    logic [SUM_BITS-1:0]    r_sum,      n_sum;
    logic [2:0]             r_closed,   n_closed;

    logic                   running;
    logic                   first_byte;
    logic                   go;
    logic                   is_digit;
    logic [2:0]             digit;
    logic [MODE_BITS-1:0]   mode_eff;
    logic [SIZE_BITS-1:0]   size_eff;
    logic [SUM_BITS-1:0]    sum_eff;
    logic [2:0]             closed_eff;
    logic [SIZE_BITS:0]     size_round;
    logic [SKIP_BITS-1:0]   skip_blocks;
    logic [INDEX_BITS-1:0]  files_inc;
    logic [OFFSET_BITS-1:0] offset_inc;

    // Decode the byte and position
    always_comb begin
        running    = (r_phase == PH_HEADER) || (r_phase == PH_SKIP);
        first_byte = (r_byte_pos == '0);
        is_digit   = (i_data_byte >= 8'h30) && (i_data_byte <= 8'h37);
        digit      = i_data_byte[2:0];
        mode_eff   = first_byte ? '0 : r_mode;
        size_eff   = first_byte ? '0 : r_size;
        sum_eff    = first_byte ? '0 : r_sum;
        closed_eff = first_byte ? '0 : r_closed;
        files_inc  = r_files + INDEX_BITS'(1);
        offset_inc = r_offset + OFFSET_BITS'(1);
    end

    // Next state and result
    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_skip      = r_skip;
        n_offset    = r_offset;
        n_files     = r_files;
        n_mode      = r_mode;
        n_size      = r_size;
        n_sum       = r_sum;
        n_closed    = r_closed;
        o_res_valid = 1'b0;
        o_res       = '0;
        go          = 1'b0;
        size_round  = '0;
        skip_blocks = '0;

        if (i_valid) begin
            if (r_phase == PH_HEADER) begin
                go = 1'b1;
                // stop checks at the first byte of a header
                if (first_byte) begin
                    if (r_files >= i_file_limit) begin
                        o_res_valid     = 1'b1;
                        o_res.file_index = r_files;
                        o_res.end_kind  = END_LIMIT;
                        n_phase         = PH_DONE;
                        go              = 1'b0;
                    end else if (i_data_byte == 8'h00) begin
                        o_res_valid     = 1'b1;
                        o_res.file_index = r_files;
                        o_res.end_kind  = END_ZERO;
                        n_phase         = PH_DONE;
                        go              = 1'b0;
                    end
                end

                if (go) begin
                    n_mode   = mode_eff;
                    n_size   = size_eff;
                    n_sum    = sum_eff;
                    n_closed = closed_eff;

                    // shift octal digits in, close the field on anything else
                    if ((r_byte_pos >= BLOCK_BITS'(MODE_AT)) &&
                        (r_byte_pos <  BLOCK_BITS'(MODE_AT + MODE_LEN)) &&
                        !closed_eff[0]) begin
                        if (is_digit) n_mode = {mode_eff[MODE_BITS-4:0], digit};
                        else          n_closed[0] = 1'b1;
                    end
                    if ((r_byte_pos >= BLOCK_BITS'(SIZE_AT)) &&
                        (r_byte_pos <  BLOCK_BITS'(SIZE_AT + SIZE_LEN)) &&
                        !closed_eff[1]) begin
                        if (is_digit) n_size = {size_eff[SIZE_BITS-4:0], digit};
                        else          n_closed[1] = 1'b1;
                    end
                    if ((r_byte_pos >= BLOCK_BITS'(SUM_AT)) &&
                        (r_byte_pos <  BLOCK_BITS'(SUM_AT + SUM_LEN)) &&
                        !closed_eff[2]) begin
                        if (is_digit) n_sum = {sum_eff[SUM_BITS-4:0], digit};
                        else          n_closed[2] = 1'b1;
                    end

                    // header complete: emit the record and set up the skip
                    if (r_byte_pos == LAST_IN_BLOCK) begin
                        size_round  = {1'b0, n_size} + (SIZE_BITS+1)'(BLOCK_BYTES - 1);
                        skip_blocks = size_round[SIZE_BITS:BLOCK_BITS];
                        n_skip      = skip_blocks;
                        n_phase     = (skip_blocks != '0) ? PH_SKIP : PH_HEADER;
                        n_files     = files_inc;

                        o_res_valid       = 1'b1;
                        o_res.record_valid = 1'b1;
                        o_res.file_index  = r_files;
                        o_res.data_offset = offset_inc;
                        o_res.file_mode   = n_mode;
                        o_res.file_size   = n_size;
                        o_res.header_sum  = n_sum;
                        if (files_inc >= i_file_limit) begin
                            o_res.end_kind = END_LIMIT;
                            n_phase        = PH_DONE;
                        end else if (i_last_byte) begin
                            o_res.end_kind = END_STREAM;
                        end else begin
                            o_res.end_kind = END_NONE;
                        end
                    end
                    n_byte_pos = r_byte_pos + BLOCK_BITS'(1);
                end
            end else if (r_phase == PH_SKIP) begin
                // count down data blocks
                if (r_byte_pos == LAST_IN_BLOCK) begin
                    n_skip = r_skip - SKIP_BITS'(1);
                    if (n_skip == '0) n_phase = PH_HEADER;
                end
                n_byte_pos = r_byte_pos + BLOCK_BITS'(1);
            end

            if (running) n_offset = offset_inc;

            // stream end: report and restart the walk
            if (i_last_byte) begin
                if (running && !o_res_valid) begin
                    o_res_valid      = 1'b1;
                    o_res.file_index = r_files;
                    o_res.end_kind   = END_STREAM;
                end
                n_phase    = PH_HEADER;
                n_byte_pos = '0;
                n_skip     = '0;
                n_offset   = '0;
                n_files    = '0;
                n_mode     = '0;
                n_size     = '0;
                n_sum      = '0;
                n_closed   = '0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_byte_pos <= '0;
            r_skip     <= '0;
            r_offset   <= '0;
            r_files    <= '0;
            r_mode     <= '0;
            r_size     <= '0;
            r_sum      <= '0;
            r_closed   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_pos <= n_byte_pos;
            r_skip     <= n_skip;
            r_offset   <= n_offset;
            r_files    <= n_files;
            r_mode     <= n_mode;
            r_size     <= n_size;
            r_sum      <= n_sum;
            r_closed   <= n_closed;
        end
    end

endmodule

// ===== sv/thw_out_queue.sv =====
// ============================================================================
// thw_out_queue
// Two-entry result queue that decouples the walker from a stalling receiver.
// ============================================================================
module thw_out_queue
    import thw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_thw_result  i_data,
    input  logic         i_ready,
    output logic         o_valid,
    output t_thw_result  o_data,
    output t_thw_qstat   o_stat
);

    t_thw_result r_mem [0:1];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        pop;

    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    assign o_stat.count = r_count;
    assign o_stat.pop   = pop;

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

// ===== sv/tar_header_walker_unit.sv =====
// ============================================================================
// tar_header_walker_unit
// Streaming tar archive walker that emits one record per file header.
// ============================================================================
// Usage:
//   Archive bytes enter on the s_axis channel, one byte per beat, in order;
//   s_axis_tlast marks the final byte of the archive and restarts the walk.
//   Each header block yields a file record on m_axis; a zero header, the
//   file limit or the archive end yields an end result (tuser end kind).
//   The file limit register lies at APB address 0 and resets to 64; write
//   it only while no byte is in flight.
// Pipeline and throughput:
//   One byte per cycle while the result queue has room. A byte is registered
//   at its beat and walked in the next cycle; its result is written into the
//   result queue and offered on m_axis from there. The per-byte rate is set
//   by the single walk step: a block counter, an offset increment, an octal shift.
// Reset and stalls:
//   Synchronous reset restarts the walk at offset zero and empties the
//   two-entry result queue. When m_axis stalls, results wait in the queue
//   and s_axis_tready drops only once the queue would overflow.
// ============================================================================
module tar_header_walker_unit
    import thw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // s_axis_tdata: [7:0] data_byte
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                      s_axis_tlast,
    // m_axis_tdata: [15:0] file_index, [49:16] data_offset, [70:50] file_mode,
    //               [103:71] file_size, [124:104] header_sum, [127:125] zero
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    // m_axis_tuser: [0] record_valid, [2:1] end_kind
    output logic [OUT_USER_BITS-1:0]  m_axis_tuser,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic [LIMIT_BITS-1:0] r_file_limit;

    logic                  res_valid;
    t_thw_result           res;
    t_thw_result           q_data;
    t_thw_qstat            q_stat;
    logic [2:0]            q_load;
    logic                  in_beat;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FILE_LIMIT) ? {16'd0, r_file_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_limit <= LIMIT_BITS'(LIMIT_RESET);
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_FILE_LIMIT)) begin
            r_file_limit <= pwdata[LIMIT_BITS-1:0];
        end
    end

    // Accept a beat only when the queue keeps room for the byte in flight
    assign q_load        = 3'(q_stat.count) + 3'(r_in_valid);
    assign s_axis_tready = (q_load <= 3'(q_stat.pop) + 3'd1);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    thw_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_file_limit (r_file_limit),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    thw_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    // Pack the output beat
    assign m_axis_tdata = {3'd0, q_data.header_sum, q_data.file_size, q_data.file_mode,
                           q_data.data_offset, q_data.file_index};
    assign m_axis_tuser = {q_data.end_kind, q_data.record_valid};

endmodule

// ===== sv/thw_checker.sv =====
// ============================================================================
// thw_checker
// Port-level checks for the tar header walker, bound to the top level.
// ============================================================================
module thw_checker
    import thw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic [OUT_USER_BITS-1:0]  m_axis_tuser
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // Stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // End results carry only the file count
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[OUT_DATA_BITS-1:INDEX_BITS] == '0)
        else $error("end result carries record fields");

    // A result without a record must report why the walk ended
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[2:1] != END_NONE)
        else $error("end result without end kind");

endmodule

bind tar_header_walker_unit thw_checker u_thw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
